/* design/mvt_pkg.sv */
// Shared types, constants and helpers for the 4x4 vertex transform block.
package mvt_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned SHIFT_W   = PROD_W - FRAC_BITS;
  // four truncated products summed exactly
  localparam int unsigned ACC_W     = SHIFT_W + 2;
  localparam int unsigned IDX_W     = 4;

  localparam logic [1:0] OP_WR_CUR  = 2'd0;
  localparam logic [1:0] OP_WR_OPD  = 2'd1;
  localparam logic [1:0] OP_COMPOSE = 2'd2;
  localparam logic [1:0] OP_XFORM   = 2'd3;

  localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]               operation;
    logic [IDX_W-1:0]         element_index;
    logic signed [DATA_W-1:0] element_value;
    logic signed [DATA_W-1:0] coord_x;
    logic signed [DATA_W-1:0] coord_y;
    logic signed [DATA_W-1:0] coord_z;
    logic signed [DATA_W-1:0] coord_w;
  } mvt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
  } mvt_out_t;

  // tag that travels with a product through the accumulate stage
  typedef struct packed {
    logic             first;
    logic             last;
    logic [IDX_W-1:0] dst;
  } mac_tag_t;

  // identity matrix element, column-major index col*4+row
  function automatic logic [DATA_W-1:0] ident_elem(logic [IDX_W-1:0] idx);
    return (idx[3:2] == idx[1:0]) ? FX_ONE : '0;
  endfunction

endpackage

/* design/mvt_in_if.sv */
// Input channel: one operation word per handshake.
interface mvt_in_if;
  import mvt_pkg::*;

  logic    valid;
  logic    ready;
  mvt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/mvt_out_if.sv */
// Output channel: one transformed vector word per handshake.
interface mvt_out_if;
  import mvt_pkg::*;

  logic     valid;
  logic     ready;
  mvt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/matrix4_vertex_transform_top.sv */
// 4x4 homogeneous matrix-vector transform unit, signed Q16.16 fixed point.
//
// Keeps a current matrix and an operand matrix (column-major, index col*4+row,
// both identity after reset). Input words: write a current element, write an
// operand element, compose current = current x operand, or transform a point.
// Only a transform returns an output word. All arithmetic runs through one
// 32x32 multiplier followed by one accumulate/saturate stage, one
// multiply-accumulate per cycle. An element write completes as it is
// accepted. A transform computes four dot products, then passes through a
// drain and a flush state: the next word is taken once the flush finds the
// output register free. A compose computes sixteen dot products, then
// passes through a drain state before the next word is taken. The product
// is built in a second bank of the current matrix, which becomes the active
// bank when the compose ends, so no copy is needed. Products are
// floor-truncated by FRAC_BITS; the four products of a dot product are
// summed exactly and saturated once to 32 bits. A finished result sits in
// the output register while the next word is accepted.
module matrix4_vertex_transform_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvt_in_if.sink    in_i,
  mvt_out_if.source out_o
);
  import mvt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // sequencer: step = {col, row, k}
  logic [5:0] step_q, step_d;
  logic       tf_q, tf_d;      // 1: transform, 0: compose
  logic       sel_q, sel_d;    // active bank of the current matrix

  logic [DATA_W-1:0] cur_q [2][16];
  logic [DATA_W-1:0] opd_q [16];
  logic [DATA_W-1:0] pt_q  [4];
  logic [DATA_W-1:0] res_q [4];

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic                     pv_q;
  mac_tag_t                 ptag_q, ptag_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  logic     out_valid_q;
  mvt_out_t out_data_q;

  logic in_fire;
  logic last_issue;
  logic [1:0] k_s, row_s, col_s;
  logic signed [DATA_W-1:0]  op_a, op_b;
  logic signed [SHIFT_W-1:0] sh;
  logic                      fits;
  logic [DATA_W-1:0]         sat_val;
  logic                      wr_res;
  logic                      flush_go;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign k_s   = step_q[1:0];
  assign row_s = step_q[3:2];
  assign col_s = step_q[5:4];

  // issue: one product per cycle
  assign op_a   = cur_q[sel_q][{k_s, row_s}];
  assign op_b   = tf_q ? pt_q[k_s] : opd_q[{col_s, k_s}];
  assign prod_d = op_a * op_b;

  assign ptag_d.first = (k_s == 2'd0);
  assign ptag_d.last  = (k_s == 2'd3);
  assign ptag_d.dst   = {col_s, row_s};

  assign last_issue = tf_q ? (step_q[3:0] == 4'hF) : (step_q == 6'h3F);

  // accumulate and saturate
  assign sh    = SHIFT_W'(prod_q >>> FRAC_BITS);
  assign acc_d = (ptag_q.first ? ACC_W'(0) : acc_q) + ACC_W'(sh);
  assign fits  = (&acc_d[ACC_W-1:DATA_W-1]) || !(|acc_d[ACC_W-1:DATA_W-1]);
  assign sat_val = fits ? acc_d[DATA_W-1:0]
                        : (acc_d[ACC_W-1] ? SAT_MIN : SAT_MAX);
  assign wr_res  = pv_q && ptag_q.last;

  assign flush_go = (state_q == ST_FLUSH) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    tf_d    = tf_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.data.operation == OP_COMPOSE ||
                        in_i.data.operation == OP_XFORM)) begin
          state_d = ST_CALC;
          step_d  = '0;
          tf_d    = (in_i.data.operation == OP_XFORM);
        end
      end
      ST_CALC: begin
        step_d = step_q + 6'd1;
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tf_q) begin
          state_d = ST_FLUSH;
        end else begin
          sel_d   = ~sel_q;
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      tf_q        <= 1'b0;
      sel_q       <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      tf_q    <= tf_d;
      sel_q   <= sel_d;
      pv_q    <= (state_q == ST_CALC);
      if (flush_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // matrix storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        cur_q[0][i] <= ident_elem(IDX_W'(i));
        cur_q[1][i] <= ident_elem(IDX_W'(i));
        opd_q[i]    <= ident_elem(IDX_W'(i));
      end
    end else begin
      if (in_fire && in_i.data.operation == OP_WR_CUR) begin
        cur_q[sel_q][in_i.data.element_index] <= in_i.data.element_value;
      end
      if (in_fire && in_i.data.operation == OP_WR_OPD) begin
        opd_q[in_i.data.element_index] <= in_i.data.element_value;
      end
      if (wr_res && !tf_q) begin
        cur_q[~sel_q][ptag_q.dst] <= sat_val;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pt_q[0] <= in_i.data.coord_x;
      pt_q[1] <= in_i.data.coord_y;
      pt_q[2] <= in_i.data.coord_z;
      pt_q[3] <= in_i.data.coord_w;
    end
    prod_q <= prod_d;
    ptag_q <= ptag_d;
    if (pv_q) begin
      acc_q <= acc_d;
    end
    if (wr_res && tf_q) begin
      res_q[ptag_q.dst[1:0]] <= sat_val;
    end
    if (flush_go) begin
      out_data_q.out_x <= res_q[0];
      out_data_q.out_y <= res_q[1];
      out_data_q.out_z <= res_q[2];
      out_data_q.out_w <= res_q[3];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // the drain cycle always sees the final product of the last dot product
  a_drain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (pv_q && ptag_q.last))
    else $error("drain without final product");

  // a finished compose swaps the active bank
  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && !tf_q) |=> (sel_q != $past(sel_q)))
    else $error("compose did not swap bank");

  // a new output word only comes from the flush state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FLUSH))
    else $error("output word loaded outside flush");

  // every operation starts at the first step
  a_step_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && $past(state_q == ST_IDLE)) |-> (step_q == 6'd0))
    else $error("sequencer did not start at step zero");

endmodule

/* sim/matrix4_vertex_transform_top_tb.sv */
// Self-checking testbench for the 4x4 fixed-point vertex transform block.
`timescale 1ns / 1ps

module matrix4_vertex_transform_top_tb;
  import mvt_pkg::*;

  localparam int RANDOM_WORDS = 650;
  localparam int CALM_WORDS   = 100;   // tail of the run with no idling at all
  localparam int LONG_HOLD    = 400;   // sink hold-off, long enough to back up the input
  localparam int DRAIN_CYCLES = 100;   // longer than a compose takes
  localparam int MAX_LOGGED   = 30;

  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  localparam logic signed [DATA_W-1:0] ONE  = FX_ONE;
  localparam logic signed [DATA_W-1:0] HALF = FX_ONE >> 1;
  localparam logic signed [DATA_W-1:0] MAXV = SAT_MAX;
  localparam logic signed [DATA_W-1:0] MINV = SAT_MIN;

  // Tracks both matrices, predicts each transformed vector and checks the
  // output words against the predictions in order.
  class xform_scoreboard;
    logic signed [DATA_W-1:0] cur_m [16];
    logic signed [DATA_W-1:0] opd_m [16];
    mvt_out_t vectors_due [$];
    bit hit_bound;
    int mismatches, n_checked, n_writes, n_composes, n_points, n_clamped;

    function new();
      for (int i = 0; i < 16; i++) begin
        cur_m[i] = (i / 4 == i % 4) ? ONE : '0;
        opd_m[i] = (i / 4 == i % 4) ? ONE : '0;
      end
    endfunction

    // full product, low fraction bits dropped (floor)
    function longint fx_prod(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
      return (longint'(a) * longint'(b)) >>> FRAC_BITS;
    endfunction

    function logic signed [DATA_W-1:0] clamp32(longint s);
      if (s > SUM_HI) begin
        hit_bound = 1'b1;
        return MAXV;
      end
      if (s < SUM_LO) begin
        hit_bound = 1'b1;
        return MINV;
      end
      return s[DATA_W-1:0];
    endfunction

    function void note_word(mvt_in_t w);
      logic signed [DATA_W-1:0] nxt [16];
      logic signed [DATA_W-1:0] pt [4];
      logic signed [DATA_W-1:0] vec [4];
      longint acc;
      case (w.operation)
        OP_WR_CUR: begin
          cur_m[w.element_index] = w.element_value;
          n_writes++;
        end
        OP_WR_OPD: begin
          opd_m[w.element_index] = w.element_value;
          n_writes++;
        end
        OP_COMPOSE: begin
          for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
              acc = 0;
              for (int k = 0; k < 4; k++) acc += fx_prod(cur_m[k*4+row], opd_m[col*4+k]);
              nxt[col*4+row] = clamp32(acc);
            end
          end
          cur_m = nxt;
          n_composes++;
        end
        OP_XFORM: begin
          pt = '{w.coord_x, w.coord_y, w.coord_z, w.coord_w};
          hit_bound = 1'b0;
          for (int row = 0; row < 4; row++) begin
            acc = 0;
            for (int col = 0; col < 4; col++) acc += fx_prod(cur_m[col*4+row], pt[col]);
            vec[row] = clamp32(acc);
          end
          vectors_due.push_back('{vec[0], vec[1], vec[2], vec[3]});
          n_points++;
          if (hit_bound) n_clamped++;
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_LOGGED) begin
        $display("%0t ns: vector %0d mismatch: %s", $time, n_checked, what);
      end
    endtask

    task check_vector(mvt_out_t got);
      mvt_out_t want;
      string lane_name [4] = '{"out_x", "out_y", "out_z", "out_w"};
      n_checked++;
      if (vectors_due.size() == 0) begin
        flag_mismatch("output word with no transform outstanding");
        return;
      end
      want = vectors_due.pop_front();
      for (int f = 0; f < 4; f++) begin
        if (got[(3-f)*DATA_W +: DATA_W] !== want[(3-f)*DATA_W +: DATA_W]) begin
          flag_mismatch($sformatf("%s got %h, want %h", lane_name[f],
                                  got[(3-f)*DATA_W +: DATA_W],
                                  want[(3-f)*DATA_W +: DATA_W]));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;       // no idling on either side
  bit   hold_req;   // ask the sink process for one long hold-off
  int   words_sent;

  mvt_in_if  in_if ();
  mvt_out_if out_if ();

  xform_scoreboard sb;

  matrix4_vertex_transform_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: everything sampled at the rising edge, before the drivers'
  // nonblocking updates land.
  always @(posedge clk) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) sb.check_vector(out_if.data);
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1) sb.note_word(in_if.data);
  end

  // Sink: random stall bursts, plus one long hold-off on request. Every
  // branch assigns ready once and then waits at least one edge.
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Word builders. Fields a word ignores carry random bits so that every
  // input bit toggles.
  // ---------------------------------------------------------------------
  function automatic mvt_in_t noise_word();
    logic [6*32-1:0] noise_bits;
    noise_bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return noise_bits[$bits(mvt_in_t)-1:0];
  endfunction

  function automatic mvt_in_t write_word(logic [1:0] op, logic [IDX_W-1:0] idx,
                                         logic signed [DATA_W-1:0] val);
    mvt_in_t w = noise_word();
    w.operation     = op;
    w.element_index = idx;
    w.element_value = val;
    return w;
  endfunction

  function automatic mvt_in_t compose_word();
    mvt_in_t w = noise_word();
    w.operation = OP_COMPOSE;
    return w;
  endfunction

  function automatic mvt_in_t point_word(logic signed [DATA_W-1:0] x,
                                         logic signed [DATA_W-1:0] y,
                                         logic signed [DATA_W-1:0] z,
                                         logic signed [DATA_W-1:0] wc);
    mvt_in_t w = noise_word();
    w.operation = OP_XFORM;
    w.coord_x   = x;
    w.coord_y   = y;
    w.coord_z   = z;
    w.coord_w   = wc;
    return w;
  endfunction

  // mostly moderate elements (about +-2.0 to +-16.0) so composes stay in range
  function automatic logic signed [DATA_W-1:0] rand_elem();
    case ($urandom_range(0, 15))
      0:       return MAXV;
      1:       return MINV;
      2:       return '0;
      3:       return ONE;
      4:       return $urandom();
      default: return signed'($urandom()) >>> $urandom_range(11, 14);
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return signed'($urandom()) >>> $urandom_range(8, 12);
  endfunction

  // w = 1.0 half of the time: plain 3-component points
  function automatic mvt_in_t rand_point();
    return point_word(rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 1) ? ONE : rand_coord());
  endfunction

  // ---------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------
  task automatic idle_in(int n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Offer one word and hold it until the block takes it.
  task automatic send_word(mvt_in_t w);
    if (!calm && $urandom_range(0, 5) == 0) idle_in($urandom_range(1, 18));
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    words_sent++;
  endtask

  // Sender pause until every predicted vector has come out.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.vectors_due.size() != 0);
  endtask

  // Directed words: field extremes, every operation, saturation both ways,
  // floor rounding of negative products, and that compose keeps the operand.
  task automatic run_directed();
    // identity after reset passes the point straight through
    send_word(point_word(ONE, -ONE, MAXV, MINV));
    send_word(write_word(OP_WR_CUR, 4'd0, MAXV));
    send_word(write_word(OP_WR_CUR, 4'd15, MINV));
    // x saturates high, w saturates low
    send_word(point_word(MAXV, ONE, '0, MAXV));
    // opposite signs: x saturates low, w (MIN*MIN) saturates high
    send_word(point_word(MINV, MINV, MINV, MINV));
    send_word(write_word(OP_WR_CUR, 4'd0, HALF));
    send_word(write_word(OP_WR_CUR, 4'd15, ONE));
    // 0.5 * -1 lsb rounds down to -1 lsb
    send_word(point_word(32'shFFFF_FFFF, 32'sd1, ONE, ONE));
    send_word(write_word(OP_WR_OPD, 4'd5, ONE <<< 1));
    send_word(write_word(OP_WR_OPD, 4'd10, -HALF));
    send_word(write_word(OP_WR_OPD, 4'd12, 3 * ONE));
    send_word(write_word(OP_WR_OPD, 4'd0, MAXV));
    send_word(write_word(OP_WR_CUR, 4'd12, MAXV));
    // translation column adds to a max element: saturates high
    send_word(compose_word());
    send_word(point_word($urandom(), $urandom(), $urandom(), $urandom()));
    send_word(point_word(ONE, -HALF, 5 * ONE, ONE));
    send_word(write_word(OP_WR_OPD, 4'd15, MINV));
    send_word(write_word(OP_WR_CUR, 4'd3, MINV));
    // MIN times 3.0 in the bottom-right element: saturates low
    send_word(compose_word());
    send_word(point_word(ONE, ONE, ONE, ONE));
    // second compose with the same operand
    send_word(compose_word());
    send_word(point_word($urandom(), $urandom(), $urandom(), $urandom()));
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int stop_at;
    int scene;
    sb = new();
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_drained();

    // Random part: mostly whole-matrix loads and composes followed by a
    // few points, with some single writes and noise words in between.
    stop_at = words_sent + RANDOM_WORDS;
    scene   = 0;
    while (words_sent < stop_at) begin
      calm = (words_sent >= stop_at - CALM_WORDS);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (int i = 0; i < 16; i++) send_word(write_word(OP_WR_CUR, 4'(i), rand_elem()));
        end
        3, 4: begin
          for (int i = 0; i < 16; i++) send_word(write_word(OP_WR_OPD, 4'(i), rand_elem()));
          send_word(compose_word());
        end
        5: repeat (3) send_word(write_word($urandom_range(0, 1) ? OP_WR_OPD : OP_WR_CUR,
                                           4'($urandom_range(0, 15)), rand_elem()));
        6: send_word(compose_word());
        7: repeat (4) send_word(noise_word());
        default: ;
      endcase
      repeat ($urandom_range(1, 6)) send_word(rand_point());

      // back-pressure: sink holds off while points keep coming
      if (scene == 8) begin
        hold_req = 1'b1;
        repeat (8) send_word(rand_point());
      end
      if (scene == 20) wait_drained();
      scene++;
    end

    in_if.valid <= 1'b0;
    while (sb.vectors_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d words in, %0d element writes, %0d composes, %0d points transformed",
             words_sent, sb.n_writes, sb.n_composes, sb.n_points);
    $display("     %0d vectors hit a saturation bound; one %0d-cycle sink hold-off; %0d mismatches",
             sb.n_clamped, LONG_HOLD, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("matrix4_vertex_transform_top regression: pass");
    end else begin
      $display("matrix4_vertex_transform_top regression: fail");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout with %0d vectors still outstanding", sb.vectors_due.size());
    $display("matrix4_vertex_transform_top regression: fail");
    $finish;
  end

endmodule
